// ----- hdl/waypoint_flight_sequencer_unit_assert.svh -----
// Assertion macros used by the sequencer control module.
`ifndef WAYPOINT_FLIGHT_SEQUENCER_UNIT_ASSERT_SVH
`define WAYPOINT_FLIGHT_SEQUENCER_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define WFS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");

// The consequence must hold in the cycle after the antecedent.
`define WFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");

`endif

// ----- hdl/wfs_pkg.sv -----
package wfs_pkg;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_LAUNCH = 3'd1,
    M_HOVER  = 3'd2,
    M_TURN   = 3'd3,
    M_CRUISE = 3'd4,
    M_BRAKE  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ITER,
    S_FIN
  } ctrl_state_t;

  localparam logic [2:0] REG_GOAL_X      = 3'd0;
  localparam logic [2:0] REG_GOAL_Y      = 3'd1;
  localparam logic [2:0] REG_TOLERANCE   = 3'd2;
  localparam logic [2:0] REG_CRUISE_H    = 3'd3;
  localparam logic [2:0] REG_LAUNCH_H    = 3'd4;
  localparam logic [2:0] REG_AIRBORNE_H  = 3'd5;
  localparam logic [2:0] REG_TICK_LIMIT  = 3'd6;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int SQRT_STEPS = 25;
  localparam int STEP_W = 5;

  localparam int PI_Q12      = 12868;
  localparam int TWO_PI_Q12  = 25736;
  localparam int WINDOW_Q12  = 410;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int STOP_VEL    = 41;

  typedef struct packed {
    logic              load;
    logic              mul1;
    logic              mul2;
    logic              step;
    logic              commit;
    logic [STEP_W-1:0] step_idx;
  } wfs_cmd_t;

  // Arctangent of 2^-i in Q16 radians, rounded to nearest.
  function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/wfs_in_if.sv -----
interface wfs_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [23:0] pos_x;
  logic [23:0] pos_y;
  logic [23:0] pos_z;
  logic [14:0] heading;
  logic [23:0] vel_x;
  logic [23:0] vel_y;

  modport source (output valid, func, pos_x, pos_y, pos_z, heading, vel_x, vel_y,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, heading, vel_x, vel_y,
                output ready);
endinterface

// ----- hdl/wfs_out_if.sv -----
interface wfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  turn_dir;
  logic [1:0]  climb_dir;
  logic        forward_cmd;
  logic [2:0]  mode;
  logic        busy_res;
  logic [23:0] goal_distance;

  modport source (output valid, turn_dir, climb_dir, forward_cmd, mode, busy_res,
                  goal_distance, input ready);
  modport sink (input valid, turn_dir, climb_dir, forward_cmd, mode, busy_res,
                goal_distance, output ready);
endinterface

// ----- hdl/wfs_ctrl.sv -----
module wfs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output wfs_pkg::wfs_cmd_t cmd
);
  import wfs_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SQRT_STEPS - 1);

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        cnt_next   = '0;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.step     = 1'b1;
        cmd.step_idx = cnt;
        if (cnt == LAST_STEP) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FIN: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

`include "waypoint_flight_sequencer_unit_assert.svh"

  `WFS_ASSERT_NEXT(a_iter_ends, clk, rst, (state == S_ITER && cnt == LAST_STEP), (state == S_FIN))
  `WFS_ASSERT_NEXT(a_commit_valid, clk, rst, cmd.commit, out_valid)
  `WFS_ASSERT_IMP(a_no_overwrite, clk, rst, (out_valid && !out_ready), !cmd.commit)

endmodule

// ----- hdl/wfs_datapath.sv -----
module wfs_datapath #(
  parameter int ANGLE_ITERATIONS = wfs_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  wfs_pkg::wfs_cmd_t cmd,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [23:0]       wr_data,
  input  logic              func,
  input  logic [23:0]       pos_x,
  input  logic [23:0]       pos_y,
  input  logic [23:0]       pos_z,
  input  logic [14:0]       heading,
  input  logic [23:0]       vel_x,
  input  logic [23:0]       vel_y,
  output logic [1:0]        turn_dir,
  output logic [1:0]        climb_dir,
  output logic              forward_cmd,
  output logic [2:0]        mode,
  output logic              busy_res,
  output logic [23:0]       goal_distance
);
  import wfs_pkg::*;

  // Configuration registers.
  logic signed [23:0] goal_x, goal_y;
  logic [23:0]        tol;
  logic [7:0]         cruise_h, launch_h, air_h, tick_lim;

  // Captured item.
  logic               func_q;
  logic signed [23:0] pz, vx, vy;
  logic signed [14:0] hd;
  logic signed [24:0] dx, dy;

  // Square root and vectoring state.
  logic [49:0]        sq, nrad;
  logic [26:0]        rem;
  logic [24:0]        root;
  logic signed [27:0] cx, cy;
  logic signed [19:0] cz;
  logic               crun;

  // Mission state.
  mode_t      fmode, fmode_next;
  logic [7:0] ticks, ticks_next;
  logic       fwd, fwd_next;
  logic signed [1:0] turn_next, climb_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x   <= '0;
      goal_y   <= '0;
      tol      <= 24'd2048;
      cruise_h <= 8'd10;
      launch_h <= 8'd20;
      air_h    <= 8'd2;
      tick_lim <= 8'd50;
    end else if (wr_en) begin
      case (wr_index)
        REG_GOAL_X:     goal_x   <= wr_data;
        REG_GOAL_Y:     goal_y   <= wr_data;
        REG_TOLERANCE:  tol      <= wr_data;
        REG_CRUISE_H:   cruise_h <= wr_data[7:0];
        REG_LAUNCH_H:   launch_h <= wr_data[7:0];
        REG_AIRBORNE_H: air_h    <= wr_data[7:0];
        REG_TICK_LIMIT: tick_lim <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  logic [28:0] rem_sh, trial;
  logic signed [27:0] xs, ys;
  logic signed [19:0] atan_v;
  logic signed [24:0] mop;
  logic signed [49:0] prod;

  always_comb begin
    rem_sh = {rem, nrad[49:48]};
    trial  = {2'b00, root, 2'b01};
    xs     = cx >>> cmd.step_idx;
    ys     = cy >>> cmd.step_idx;
    atan_v = $signed({4'b0000, atan_q16(cmd.step_idx)});
    // One multiplier squares dx in the S_MUL1 step and dy in the S_MUL2 step.
    mop    = cmd.mul2 ? dy : dx;
    prod   = mop * mop;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      pz     <= pos_z;
      hd     <= heading;
      vx     <= vel_x;
      vy     <= vel_y;
      dx     <= 25'(goal_x) - 25'($signed(pos_x));
      dy     <= 25'(goal_y) - 25'($signed(pos_y));
    end
    if (cmd.mul1) begin
      sq   <= $unsigned(prod);
      crun <= (dy != '0) && (dx != '0);
      if (dx < 0 && dy != '0) begin
        // Rotate into the right half plane by a quarter turn first.
        if (dy > 0) begin
          cz <= 20'(HALF_PI_Q16);
          cx <= 28'(dy);
          cy <= -28'(dx);
        end else begin
          cz <= -20'(HALF_PI_Q16);
          cx <= -28'(dy);
          cy <= 28'(dx);
        end
      end else begin
        cx <= 28'(dx);
        cy <= 28'(dy);
        if (dy == '0) begin
          cz <= (dx >= 0) ? 20'sd0 : 20'(PI_Q16);
        end else if (dx == '0) begin
          cz <= (dy > 0) ? 20'(HALF_PI_Q16) : -20'(HALF_PI_Q16);
        end else begin
          cz <= '0;
        end
      end
    end
    if (cmd.mul2) begin
      nrad <= sq + $unsigned(prod);
      rem  <= '0;
      root <= '0;
    end
    if (cmd.step) begin
      nrad <= {nrad[47:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 27'(rem_sh - trial);
        root <= {root[23:0], 1'b1};
      end else begin
        rem  <= rem_sh[26:0];
        root <= {root[23:0], 1'b0};
      end
      if (crun && cmd.step_idx < STEP_W'(ANGLE_ITERATIONS)) begin
        if (cy > 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_v;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_v;
        end
      end
    end
  end

  function automatic logic signed [1:0] height_dir(input logic signed [23:0] z,
                                                   input logic [7:0] h);
    logic signed [9:0]  lo, hi;
    logic signed [24:0] zl, zh;
    lo = $signed({2'b00, h}) - 10'sd2;
    hi = $signed({2'b00, h}) + 10'sd2;
    zl = 25'(lo) <<< 12;
    zh = 25'(hi) <<< 12;
    if (25'(z) < zl) return 2'sd1;
    if (25'(z) > zh) return -2'sd1;
    return 2'sd0;
  endfunction

  logic signed [19:0] a20;
  logic signed [15:0] ang;
  logic signed [17:0] steer;
  logic signed [1:0]  tdir;
  logic [28:0]        d10, t11;
  logic signed [24:0] air_z;

  always_comb begin
    a20   = (cz + 20'sd8) >>> 4;
    ang   = a20[15:0];
    steer = 18'(ang) - 18'(hd);
    if (steer >= 18'(PI_Q12)) begin
      steer = steer - 18'(TWO_PI_Q12);
    end else if (steer <= -18'(PI_Q12)) begin
      steer = steer + 18'(TWO_PI_Q12);
    end
    tdir  = (steer > 0) ? 2'sd1 : ((steer < 0) ? -2'sd1 : 2'sd0);
    d10   = {1'b0, root, 3'b000} + {3'b000, root, 1'b0};
    t11   = {2'b00, tol, 3'b000} + {4'b0000, tol, 1'b0} + {5'b00000, tol};
    air_z = $signed({1'b0, air_h, 16'h0000}) >>> 4;

    fmode_next = fmode;
    ticks_next = ticks;
    fwd_next   = fwd;
    turn_next  = 2'sd0;
    climb_next = 2'sd0;
    if (func_q) begin
      if (fmode == M_IDLE) begin
        fmode_next = M_LAUNCH;
        ticks_next = '0;
        fwd_next   = 1'b0;
      end
    end else begin
      case (fmode)
        M_IDLE: ;
        M_LAUNCH: begin
          climb_next = height_dir(pz, launch_h);
          fwd_next   = 1'b0;
          if (ticks != 8'hFF) ticks_next = ticks + 1'b1;
          if (25'(pz) > air_z || ticks_next >= tick_lim) fmode_next = M_HOVER;
        end
        M_HOVER: begin
          climb_next = height_dir(pz, cruise_h);
          fwd_next   = 1'b0;
          if ({4'b0000, root} > {5'b00000, tol}) begin
            fmode_next = M_TURN;
            turn_next  = tdir;
          end else begin
            fmode_next = M_IDLE;
            climb_next = 2'sd0;
          end
        end
        M_TURN: begin
          climb_next = height_dir(pz, cruise_h);
          fwd_next   = 1'b0;
          if (17'(hd) < 17'(ang) + 17'(WINDOW_Q12) &&
              17'(hd) > 17'(ang) - 17'(WINDOW_Q12)) begin
            fmode_next = M_CRUISE;
          end else begin
            turn_next = tdir;
          end
        end
        M_CRUISE: begin
          climb_next = height_dir(pz, cruise_h);
          turn_next  = tdir;
          if (d10 <= t11) begin
            fmode_next = M_BRAKE;
            fwd_next   = 1'b0;
          end else begin
            fwd_next = 1'b1;
          end
        end
        M_BRAKE: begin
          climb_next = height_dir(pz, cruise_h);
          fwd_next   = 1'b0;
          if (vx < 24'(STOP_VEL) && vy < 24'(STOP_VEL)) begin
            fmode_next = M_IDLE;
            climb_next = 2'sd0;
          end
        end
        default: begin
          fmode_next = M_IDLE;
          fwd_next   = 1'b0;
        end
      endcase
    end
    if (fmode_next == M_IDLE) fwd_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmode <= M_IDLE;
      ticks <= '0;
      fwd   <= 1'b0;
    end else if (cmd.commit) begin
      fmode <= fmode_next;
      ticks <= ticks_next;
      fwd   <= fwd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      turn_dir      <= turn_next;
      climb_dir     <= climb_next;
      forward_cmd   <= fwd_next;
      mode          <= fmode_next;
      busy_res      <= (fmode_next != M_IDLE);
      goal_distance <= root[24] ? 24'hFFFFFF : root[23:0];
    end
  end

endmodule

// ----- hdl/waypoint_flight_sequencer_unit.sv -----
// Waypoint flight sequencer.
// Configuration is written through wr_en / wr_index / wr_data, one register per
// cycle; the user must write it only while no item is in flight, as the block
// does not enforce this. Items arrive on in_ch: a start word begins a mission
// from idle, an odometry word steps the mission state machine. Every input word
// yields exactly one result word on out_ch with the turn, climb and forward
// commands, the flight mode and the saturated planar distance to the goal.
// The word is loaded at the accepting edge, S_MUL1 and S_MUL2 form the squares,
// 25 square root steps follow (one result bit each, with the CORDIC bearing
// running alongside) and S_FIN commits the result. The block works on one item
// at a time; in_ch.ready is high while the sequencer is idle.
// The result register frees the input side: the next item is accepted while a
// result waits, and only its commit stalls until out_ch takes the old word.
// Reset clears the mission to idle and loads the default configuration.
module waypoint_flight_sequencer_unit #(
  parameter int ANGLE_ITERATIONS = wfs_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [23:0] wr_data,
  wfs_in_if.sink      in_ch,
  wfs_out_if.source   out_ch
);
  import wfs_pkg::*;

  wfs_cmd_t cmd;

  wfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  wfs_datapath #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .func          (in_ch.func),
    .pos_x         (in_ch.pos_x),
    .pos_y         (in_ch.pos_y),
    .pos_z         (in_ch.pos_z),
    .heading       (in_ch.heading),
    .vel_x         (in_ch.vel_x),
    .vel_y         (in_ch.vel_y),
    .turn_dir      (out_ch.turn_dir),
    .climb_dir     (out_ch.climb_dir),
    .forward_cmd   (out_ch.forward_cmd),
    .mode          (out_ch.mode),
    .busy_res      (out_ch.busy_res),
    .goal_distance (out_ch.goal_distance)
  );

endmodule

// ----- dv/tb_waypoint_flight_sequencer_unit.sv -----
module tb_waypoint_flight_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import wfs_pkg::*;

  typedef struct packed {
    logic        func;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] pos_z;
    logic [14:0] heading;
    logic [23:0] vel_x;
    logic [23:0] vel_y;
  } odo_word_t;

  typedef struct packed {
    logic [1:0]  turn_dir;
    logic [1:0]  climb_dir;
    logic        forward_cmd;
    logic [2:0]  mode;
    logic        busy_res;
    logic [23:0] goal_distance;
  } cmd_word_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [23:0] wr_data = '0;

  wfs_in_if  in_ch ();
  wfs_out_if out_ch ();

  waypoint_flight_sequencer_unit i_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // Predictor state and its copy of the registers.
  logic signed [23:0] goal_x_q, goal_y_q;
  logic [23:0]        tol_q;
  logic [7:0]         cruise_h_q, launch_h_q, airborne_h_q, tick_limit_q;
  mode_t              fmode;
  logic [7:0]         lticks;
  logic               fwd_hold;

  odo_word_t pending_words[$];
  cmd_word_t expected_cmds[$];
  int        errors = 0;
  bit        stim_done = 1'b0;
  bit        hold_sink = 1'b0;
  bit        sender_pause = 1'b0;
  int        idle_cycles = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint goal_bearing(input longint y, input longint x);
    longint z, t, xs, ys;
    int atab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (y == 0) begin
      z = (x >= 0) ? 0 : PI_Q16;
    end else if (x == 0) begin
      z = (y > 0) ? HALF_PI_Q16 : -HALF_PI_Q16;
    end else begin
      if (x < 0) begin
        t = x;
        if (y > 0) begin
          z = HALF_PI_Q16; x = y; y = -t;
        end else begin
          z = -HALF_PI_Q16; x = -y; y = t;
        end
      end
      for (int i = 0; i < ANGLE_ITERATIONS_DEF; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atab[i];
        end else begin
          x -= ys; y += xs; z -= atab[i];
        end
      end
    end
    return (z + 8 + 16777216) / 16 - 1048576;
  endfunction

  function automatic int band_dir(input longint z, input logic [7:0] h);
    if (z < (longint'(h) - 2) * 4096) return 1;
    if (z > (longint'(h) + 2) * 4096) return -1;
    return 0;
  endfunction

  function automatic cmd_word_t predict_cmd(input odo_word_t w);
    cmd_word_t r;
    longint dx, dy, pz, hd, a, s;
    longint unsigned d;
    int turn, climb, tdir;
    turn = 0;
    climb = 0;
    dx = longint'(goal_x_q) - longint'($signed(w.pos_x));
    dy = longint'(goal_y_q) - longint'($signed(w.pos_y));
    pz = longint'($signed(w.pos_z));
    hd = longint'($signed(w.heading));
    d = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    if (w.func) begin
      if (fmode == M_IDLE) begin
        fmode = M_LAUNCH; lticks = 0; fwd_hold = 0;
      end
    end else if (fmode == M_LAUNCH) begin
      climb = band_dir(pz, launch_h_q);
      fwd_hold = 0;
      if (lticks < 8'd255) lticks++;
      if (pz > longint'(airborne_h_q) * 4096 || lticks >= tick_limit_q) fmode = M_HOVER;
    end else if (fmode != M_IDLE) begin
      a = goal_bearing(dy, dx);
      s = a - hd;
      if (s >= PI_Q12) s -= TWO_PI_Q12;
      else if (s <= -PI_Q12) s += TWO_PI_Q12;
      tdir = (s > 0) ? 1 : ((s < 0) ? -1 : 0);
      climb = band_dir(pz, cruise_h_q);
      case (fmode)
        M_HOVER: begin
          fwd_hold = 0;
          if (d > tol_q) begin
            fmode = M_TURN; turn = tdir;
          end else begin
            fmode = M_IDLE; climb = 0;
          end
        end
        M_TURN: begin
          fwd_hold = 0;
          if (hd < a + WINDOW_Q12 && hd > a - WINDOW_Q12) fmode = M_CRUISE;
          else turn = tdir;
        end
        M_CRUISE: begin
          turn = tdir;
          if (d * 10 <= longint'(tol_q) * 11) begin
            fmode = M_BRAKE; fwd_hold = 0;
          end else begin
            fwd_hold = 1;
          end
        end
        default: begin
          fwd_hold = 0;
          if ($signed(w.vel_x) < STOP_VEL && $signed(w.vel_y) < STOP_VEL) begin
            fmode = M_IDLE; climb = 0;
          end
        end
      endcase
    end
    if (fmode == M_IDLE) fwd_hold = 0;
    r.turn_dir = turn[1:0];
    r.climb_dir = climb[1:0];
    r.forward_cmd = fwd_hold;
    r.mode = fmode;
    r.busy_res = (fmode != M_IDLE);
    r.goal_distance = (d > 64'hFFFFFF) ? 24'hFFFFFF : d[23:0];
    return r;
  endfunction

  // Driver.
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_cmds.push_back(predict_cmd(pending_words.pop_front()));
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120)
                                                : $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) gap_left = 0;
      end
      if (gap_left > 0) gap_left--;
      if (in_ch.valid && !in_ch.ready) begin
        // A word that waits stays on the bus until it is taken.
        in_ch.valid <= 1'b1;
      end else if (!sender_pause && gap_left == 0 && pending_words.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.func, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.heading,
         in_ch.vel_x, in_ch.vel_y} <= pending_words[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.func, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.heading,
     in_ch.vel_x, in_ch.vel_y} = '0;
    out_ch.ready = 1'b0;
  end

  // Monitor with random back-pressure.
  int stall_left = 0;
  always @(posedge clk) begin
    cmd_word_t got, exp_w;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.turn_dir, out_ch.climb_dir, out_ch.forward_cmd, out_ch.mode,
               out_ch.busy_res, out_ch.goal_distance};
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          exp_w = expected_cmds.pop_front();
          if (got !== exp_w) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_w, got);
            $display("  turn %0d/%0d climb %0d/%0d fwd %0d/%0d mode %0d/%0d",
                     exp_w.turn_dir, got.turn_dir, exp_w.climb_dir, got.climb_dir,
                     exp_w.forward_cmd, got.forward_cmd, exp_w.mode, got.mode);
            $display("  busy %0d/%0d dist %0d/%0d", exp_w.busy_res, got.busy_res,
                     exp_w.goal_distance, got.goal_distance);
            errors++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 5) == 0)
        stall_left = ($urandom_range(0, 12) == 0) ? $urandom_range(20, 150)
                                                   : $urandom_range(1, 4);
      out_ch.ready <= !hold_sink && stall_left == 0;
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (!(stim_done && expected_cmds.size() == 0))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_GOAL_X:     goal_x_q = val;
      REG_GOAL_Y:     goal_y_q = val;
      REG_TOLERANCE:  tol_q = val;
      REG_CRUISE_H:   cruise_h_q = val[7:0];
      REG_LAUNCH_H:   launch_h_q = val[7:0];
      REG_AIRBORNE_H: airborne_h_q = val[7:0];
      REG_TICK_LIMIT: tick_limit_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    wait (pending_words.size() == 0 && expected_cmds.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic odo_word_t make_word(input bit f, input int px, input int py,
                                          input int pz, input int hd,
                                          input int vx, input int vy);
    odo_word_t w;
    w.func = f; w.pos_x = 24'(px); w.pos_y = 24'(py); w.pos_z = 24'(pz);
    w.heading = 15'(hd); w.vel_x = 24'(vx); w.vel_y = 24'(vy);
    return w;
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
      1: return int'($urandom_range(0, 80000)) - 40000;
      2: return ($urandom_range(0, 1)) ? 8388607 : -8388608;
      default: return int'($urandom_range(0, 8000)) - 4000;
    endcase
  endfunction

  // One mission: start, launch ticks, then ticks that steer toward the goal.
  task automatic add_mission();
    int n, hd, vx, vy, pz;
    pending_words.push_back(make_word(1'b1, rand_pos(), rand_pos(), rand_pos(),
                                      int'($urandom_range(0, 25736)) - 12868,
                                      rand_pos(), rand_pos()));
    n = $urandom_range(1, 30);
    for (int i = 0; i < n; i++) begin
      pz = ($urandom_range(0, 3) == 0) ? rand_pos()
                                      : int'($urandom_range(0, 30 * 4096));
      hd = int'($urandom_range(0, 25736)) - 12868;
      vx = ($urandom_range(0, 1)) ? int'($urandom_range(0, 80)) - 40 : rand_pos();
      vy = ($urandom_range(0, 1)) ? int'($urandom_range(0, 80)) - 40 : rand_pos();
      pending_words.push_back(make_word($urandom_range(0, 15) == 0,
        ($urandom_range(0, 2) == 0) ? goal_x_q + int'($urandom_range(0, 4000)) - 2000
                                    : rand_pos(),
        ($urandom_range(0, 2) == 0) ? goal_y_q + int'($urandom_range(0, 4000)) - 2000
                                    : rand_pos(),
        pz, hd, vx, vy));
    end
  endtask

  initial begin
    goal_x_q = 0; goal_y_q = 0; tol_q = 24'd2048;
    cruise_h_q = 8'd10; launch_h_q = 8'd20; airborne_h_q = 8'd2; tick_limit_q = 8'd50;
    fmode = M_IDLE; lticks = 0; fwd_hold = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle tick, extremes, every mode, exact-angle cases.
    write_reg(REG_TICK_LIMIT, 24'd1);
    write_reg(REG_GOAL_X, 24'h7FFFFF);
    write_reg(REG_GOAL_Y, 24'h800000);
    pending_words.push_back(make_word(0, -8388608, 8388607, 0, 0, 0, 0));
    pending_words.push_back(make_word(1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, 0, 0, -8388608, 12868, 0, 0));
    pending_words.push_back(make_word(0, 8388607, 0, 8388607, -12868, 0, 0));
    pending_words.push_back(make_word(0, 8388607, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, 8388607, -8388608, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, 8388607, -8388608, 0, 0, 8388607, -8388608));
    pending_words.push_back(make_word(0, 8388607, -8388608, 0, 0, -8388608, -8388608));
    drain_all();
    write_reg(REG_GOAL_X, 24'd0);
    write_reg(REG_GOAL_Y, 24'd0);
    write_reg(REG_TICK_LIMIT, 24'd0);
    write_reg(REG_AIRBORNE_H, 24'd255);
    pending_words.push_back(make_word(1, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, 4096, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, -4096, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, 0, 4096, 0, 12868, 0, 0));
    pending_words.push_back(make_word(0, 0, -4096, 0, 0, 0, 0));
    pending_words.push_back(make_word(0, 0, 0, 0, 0, 40, 40));
    drain_all();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_GOAL_X, (ph == 1) ? 24'h800000 : 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_GOAL_Y, (ph == 1) ? 24'h7FFFFF : 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_TOLERANCE, (ph == 2) ? 24'hFFFFFF : (ph == 3) ? 24'd0
                                                       : 24'($urandom_range(0, 20000)));
      write_reg(REG_CRUISE_H, (ph == 2) ? 24'd255 : (ph == 3) ? 24'd0
                                                   : 24'($urandom_range(0, 30)));
      write_reg(REG_LAUNCH_H, (ph == 2) ? 24'd255 : (ph == 3) ? 24'd0
                                                   : 24'($urandom_range(0, 30)));
      write_reg(REG_AIRBORNE_H, (ph == 4) ? 24'd255 : (ph == 5) ? 24'd0
                                                     : 24'($urandom_range(0, 10)));
      write_reg(REG_TICK_LIMIT, (ph == 4) ? 24'd255 : 24'($urandom_range(0, 20)));
      while (pending_words.size() < 200) add_mission();
      if (ph == 2) begin
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      if (ph == 5) begin
        wait (pending_words.size() < 100);
        sender_pause = 1'b1;
        wait (expected_cmds.size() == 0 && !(in_ch.valid));
        sender_pause = 1'b0;
      end
      drain_all();
    end
    stim_done = 1'b1;

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
